// File: rtl/core/swg_pkg.sv
// Package for the SwiGLU activation block: sizes, sigmoid table and payload types.
package swg_pkg;

  localparam int DATA_WIDTH      = 16;
  localparam int FRAC_BITS       = 8;
  localparam int SIGMOID_ENTRIES = 256;

  localparam int SIG_W     = 17;
  localparam int SIG_FRAC  = 16;
  localparam int OFF_W     = FRAC_BITS + 4;
  localparam int IDX_W     = $clog2(SIGMOID_ENTRIES);
  localparam int P_W       = OFF_W + IDX_W;
  localparam int GS_W      = DATA_WIDTH + SIG_W + 1;
  localparam int PROD_W    = GS_W + DATA_WIDTH;
  localparam int OUT_W     = 2 * DATA_WIDTH;

  localparam logic [SIG_W-1:0] SIG_ONE = SIG_W'(1 << SIG_FRAC);

  typedef logic [SIG_W-1:0] sig_rom_t [SIGMOID_ENTRIES+1];

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] gate;
    logic signed [DATA_WIDTH-1:0] up;
    logic        [SIG_W-1:0]      sig;
  } swg_sig_t;

  function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^-y in Q30, Taylor sum with truncated terms
  function automatic logic [63:0] exp_neg_small(input logic [63:0] y);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = 64'd1 << 30;
    term = 64'd1 << 30;
    for (int n = 1; n <= 14; n++) begin
      term = udiv((term * y) >> 30, 64'(n));
      if ((n % 2) == 1) sum = sum - term;
      else              sum = sum + term;
    end
    return sum;
  endfunction

  function automatic logic [SIG_W-1:0] sig_point(input int k);
    longint      num;
    logic [63:0] mag;
    logic [63:0] a;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] s;
    num = 64'(16 * k) - 64'(8 * SIGMOID_ENTRIES);
    mag = (num < 0) ? 64'(-num) : 64'(num);
    a   = udiv(mag << 30, 64'(SIGMOID_ENTRIES));
    e   = exp_neg_small(a >> 4);
    for (int i = 0; i < 4; i++) begin
      e = (e * e + (64'd1 << 29)) >> 30;
    end
    den = (64'd1 << 30) + e;
    s   = udiv((64'd1 << 46) + (den >> 1), den);
    if (s > 64'(SIG_ONE)) s = 64'(SIG_ONE);
    if (num >= 0) return s[SIG_W-1:0];
    return SIG_ONE - s[SIG_W-1:0];
  endfunction

  function automatic sig_rom_t build_rom();
    sig_rom_t rom;
    for (int k = 0; k <= SIGMOID_ENTRIES; k++) begin
      rom[k] = sig_point(k);
    end
    return rom;
  endfunction

  localparam sig_rom_t SIG_ROM = build_rom();

endpackage

// File: rtl/core/swg_sigmoid.sv
// Three-stage sigmoid unit: range check and index, table read, interpolation.
module swg_sigmoid (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      valid_i,
  output logic                                      ready_o,
  input  logic signed [swg_pkg::DATA_WIDTH-1:0]     gate_i,
  input  logic signed [swg_pkg::DATA_WIDTH-1:0]     up_i,
  output logic                                      valid_o,
  input  logic                                      ready_i,
  output swg_pkg::swg_sig_t                         data_o
);

  localparam int DW = swg_pkg::DATA_WIDTH;
  localparam logic signed [DW:0] LIM = (DW+1)'(8 << swg_pkg::FRAC_BITS);

  // stage A
  logic                           va_q, ready_a;
  logic signed [DW-1:0]           ga_q, ua_q;
  logic                           below_a_q, above_a_q;
  logic [swg_pkg::IDX_W-1:0]      idx_a_q;
  logic [swg_pkg::OFF_W-1:0]      w_a_q;
  // stage B
  logic                           vb_q, ready_b;
  logic signed [DW-1:0]           gb_q, ub_q;
  logic                           below_b_q, above_b_q, neg_b_q;
  logic [swg_pkg::SIG_W-1:0]      lo_b_q, mag_b_q;
  logic [swg_pkg::OFF_W-1:0]      w_b_q;
  // stage C
  logic                           vc_q, ready_c;
  swg_pkg::swg_sig_t              data_c_q, data_c_d;

  logic signed [DW:0]             g_ext, off_full;
  logic [swg_pkg::OFF_W-1:0]      off;
  logic [swg_pkg::P_W-1:0]        p_d;
  logic                           below_d, above_d;
  logic [swg_pkg::IDX_W:0]        idx_lo, idx_hi;
  logic [swg_pkg::SIG_W-1:0]      lo_d, hi_d, mag_d;
  logic                           neg_d;
  logic [swg_pkg::SIG_W+swg_pkg::OFF_W-1:0] step_full;
  logic [swg_pkg::SIG_W-1:0]      step;

  assign ready_c = ~vc_q | ready_i;
  assign ready_b = ~vb_q | ready_c;
  assign ready_a = ~va_q | ready_b;
  assign ready_o = ready_a;

  always_comb begin
    g_ext    = {gate_i[DW-1], gate_i};
    below_d  = g_ext < -LIM;
    above_d  = g_ext >= LIM;
    off_full = g_ext + LIM;
    off      = off_full[swg_pkg::OFF_W-1:0];
    p_d      = swg_pkg::P_W'(off) * swg_pkg::P_W'(swg_pkg::SIGMOID_ENTRIES);
  end

  always_comb begin
    idx_lo = {1'b0, idx_a_q};
    idx_hi = idx_lo + 1'b1;
    lo_d   = swg_pkg::SIG_ROM[idx_lo];
    hi_d   = swg_pkg::SIG_ROM[idx_hi];
    neg_d  = hi_d < lo_d;
    mag_d  = neg_d ? (lo_d - hi_d) : (hi_d - lo_d);
  end

  always_comb begin
    step_full     = (swg_pkg::SIG_W+swg_pkg::OFF_W)'(mag_b_q) *
                    (swg_pkg::SIG_W+swg_pkg::OFF_W)'(w_b_q);
    step          = step_full[swg_pkg::SIG_W+swg_pkg::OFF_W-1:swg_pkg::OFF_W];
    data_c_d.gate = gb_q;
    data_c_d.up   = ub_q;
    if (below_b_q)      data_c_d.sig = '0;
    else if (above_b_q) data_c_d.sig = swg_pkg::SIG_ONE;
    else if (neg_b_q)   data_c_d.sig = lo_b_q - step;
    else                data_c_d.sig = lo_b_q + step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (ready_a) va_q <= valid_i;
      if (ready_b) vb_q <= va_q;
      if (ready_c) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_a && valid_i) begin
      ga_q      <= gate_i;
      ua_q      <= up_i;
      below_a_q <= below_d;
      above_a_q <= above_d;
      idx_a_q   <= p_d[swg_pkg::P_W-1:swg_pkg::OFF_W];
      w_a_q     <= p_d[swg_pkg::OFF_W-1:0];
    end
    if (ready_b && va_q) begin
      gb_q      <= ga_q;
      ub_q      <= ua_q;
      below_b_q <= below_a_q;
      above_b_q <= above_a_q;
      neg_b_q   <= neg_d;
      lo_b_q    <= lo_d;
      mag_b_q   <= mag_d;
      w_b_q     <= w_a_q;
    end
    if (ready_c && vb_q) begin
      data_c_q <= data_c_d;
    end
  end

  assign valid_o = vc_q;
  assign data_o  = data_c_q;

endmodule

// File: rtl/core/swg_product.sv
// Two-stage product unit: gate times sigmoid, then times up with rounding.
module swg_product (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  swg_pkg::swg_sig_t                    data_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic signed [swg_pkg::OUT_W-1:0]     product_o
);

  localparam int DW = swg_pkg::DATA_WIDTH;
  localparam logic signed [swg_pkg::PROD_W-1:0] RND =
    swg_pkg::PROD_W'(1 << (swg_pkg::SIG_FRAC - 1));

  logic                                vd_q, ready_d;
  logic signed [swg_pkg::GS_W-1:0]     gs_q, gs_d;
  logic signed [DW-1:0]                ud_q;
  logic                                ve_q, ready_e;
  logic signed [swg_pkg::OUT_W-1:0]    res_q, res_d;
  logic signed [swg_pkg::PROD_W-1:0]   prod, biased;

  assign ready_e = ~ve_q | ready_i;
  assign ready_d = ~vd_q | ready_e;
  assign ready_o = ready_d;

  always_comb begin
    gs_d   = swg_pkg::GS_W'(data_i.gate) * $signed({1'b0, data_i.sig});
    prod   = swg_pkg::PROD_W'(gs_q) * swg_pkg::PROD_W'(ud_q);
    biased = (prod + RND) >>> swg_pkg::SIG_FRAC;
    res_d  = biased[swg_pkg::OUT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else begin
      if (ready_d) vd_q <= valid_i;
      if (ready_e) ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_d && valid_i) begin
      gs_q <= gs_d;
      ud_q <= data_i.up;
    end
    if (ready_e && vd_q) begin
      res_q <= res_d;
    end
  end

  assign valid_o   = ve_q;
  assign product_o = res_q;

endmodule

// File: rtl/core/swiglu_activation_top.sv
// Top level of the SwiGLU activation block: silu(gate) * up per transfer.
//
//   channel | signals                                  | dir
//   --------+------------------------------------------+-----
//   in      | in_valid_i, in_ready_o, gate_value_i,    | in
//           | up_value_i                               |
//   out     | out_valid_o, out_ready_i, product_value_o | out
//
// Five register stages: index, table read, interpolation, gate*sigmoid,
// times up with rounding. One transfer per cycle while the output is not stalled.
// Each stage holds its own valid bit and takes new data when empty or when
// the stage after it moves, so bubbles close up under an output stall.
// Reset clears the valid bits only.
module swiglu_activation_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [swg_pkg::DATA_WIDTH-1:0] gate_value_i,
  input  logic signed [swg_pkg::DATA_WIDTH-1:0] up_value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [swg_pkg::OUT_W-1:0]      product_value_o
);

  logic              sig_valid, sig_ready;
  swg_pkg::swg_sig_t sig_data;

  swg_sigmoid u_sigmoid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .gate_i  (gate_value_i),
    .up_i    (up_value_i),
    .valid_o (sig_valid),
    .ready_i (sig_ready),
    .data_o  (sig_data)
  );

  swg_product u_product (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (sig_valid),
    .ready_o   (sig_ready),
    .data_i    (sig_data),
    .valid_o   (out_valid_o),
    .ready_i   (out_ready_i),
    .product_o (product_value_o)
  );

endmodule
